>>> rtl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
// No dependencies; used by every module under rtl/ except gsa_ram.
`default_nettype none

package gsa_pkg;

    localparam int POOL_DEPTH_DEF = 256;
    localparam int GEN_W          = 32;
    localparam int WORD_W         = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int S_TDATA_W      = 80;
    localparam int M_TDATA_W      = 48;

    localparam logic [GEN_W-1:0] GEN_INIT = 32'd1;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_DECODE = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_STALE = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_DECODE,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] slot_word;
        logic [GEN_W-1:0]  gen;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/generational_slot_allocator_unit.sv
// Generational slot allocator top level: gsa_front feeds gsa_back through a queue.
// Allocate, free and decode pass the queue, the registered RAM read (ST_WAIT) and the result
// register; rejects and empty allocates skip ST_WAIT, and no request is taken during ST_WAIT.
// Reset: synchronous; then a clearing pass over all POOL_DEPTH slots with s_tready low.
// Depends on gsa_pkg, gsa_ram, gsa_front and gsa_back.
`default_nettype none

module generational_slot_allocator_unit #(
    parameter int POOL_DEPTH = gsa_pkg::POOL_DEPTH_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // action[1:0], slot[9:2], handle[73:10], zero[79:74]
    input  wire [gsa_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // status[1:0], slot_out[9:2], generation_out[41:10], zero[47:42]
    output logic [gsa_pkg::M_TDATA_W-1:0] m_tdata
);

    logic            clearing;
    logic            q_valid;
    logic            q_ready;
    gsa_pkg::entry_t q_entry;

    gsa_front #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry)
    );

    gsa_back #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; instantiated by gsa_back for link and generation storage.
`default_nettype none

module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     wr_en,
    input  wire [$clog2(DEPTH)-1:0] wr_addr,
    input  wire [WIDTH-1:0]         wr_data,
    input  wire                     rd_en,
    input  wire [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/gsa_front.sv
// Request intake: unpacks, range-checks and classifies each request, then
// holds it in a two-entry queue for the back end (action 3 is dropped). Depends on gsa_pkg.
`default_nettype none

module gsa_front #(
    parameter int POOL_DEPTH = gsa_pkg::POOL_DEPTH_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // action[1:0], slot[9:2], handle[73:10], zero[79:74]
    input  wire [gsa_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire                           clearing,
    output logic                          q_valid,
    input  wire                           q_ready,
    output gsa_pkg::entry_t               q_entry
);

    localparam int PTR_W = $clog2(gsa_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gsa_pkg::QUEUE_DEPTH + 1);

    logic [1:0]  action;
    logic [7:0]  slot;
    logic [63:0] handle;
    logic        push;
    logic        pop;
    logic        keep;

    gsa_pkg::entry_t entry;
    gsa_pkg::entry_t fifo_reg [gsa_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign action = s_tdata[1:0];
    assign slot   = s_tdata[9:2];
    assign handle = s_tdata[73:10];

    always_comb begin
        entry.op        = gsa_pkg::OP_REJECT;
        entry.slot_word = '0;
        entry.gen       = '0;
        keep            = 1'b1;
        case (action)
            gsa_pkg::ACT_ALLOC: begin
                entry.op = gsa_pkg::OP_ALLOC;
            end
            gsa_pkg::ACT_FREE: begin
                entry.slot_word = gsa_pkg::WORD_W'(slot);
                entry.op        = (gsa_pkg::WORD_W'(slot) < gsa_pkg::WORD_W'(POOL_DEPTH))
                                  ? gsa_pkg::OP_FREE : gsa_pkg::OP_REJECT;
            end
            gsa_pkg::ACT_DECODE: begin
                entry.slot_word = handle[31:0];
                entry.gen       = handle[63:32];
                entry.op        = (handle[31:0] < gsa_pkg::WORD_W'(POOL_DEPTH))
                                  ? gsa_pkg::OP_DECODE : gsa_pkg::OP_REJECT;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !clearing && (cnt_reg != CNT_W'(gsa_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_entry  = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gsa_back.sv
// Execution sequencer: free-stack head, link and generation RAMs, reset
// clearing pass and result register. Depends on gsa_pkg and gsa_ram.
`default_nettype none

module gsa_back #(
    parameter int POOL_DEPTH = gsa_pkg::POOL_DEPTH_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    output logic                          clearing,
    input  wire                           q_valid,
    output logic                          q_ready,
    input  gsa_pkg::entry_t               q_entry,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // status[1:0], slot_out[9:2], generation_out[41:10], zero[47:42]
    output logic [gsa_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_W = $clog2(POOL_DEPTH);
    localparam int LINK_W = $clog2(POOL_DEPTH + 1);
    localparam int GEN_W  = gsa_pkg::GEN_W;
    localparam int META_W = GEN_W + 1;
    localparam int WORD_W = gsa_pkg::WORD_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [LINK_W-1:0] head_reg, head_next;
    gsa_pkg::op_t      op_reg, op_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [GEN_W-1:0]  cmp_gen_reg, cmp_gen_next;
    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [7:0]        m_slot_reg, m_slot_next;
    logic [GEN_W-1:0]  m_gen_reg, m_gen_next;

    logic              out_can;
    logic              head_empty;
    logic [SLOT_W-1:0] head_idx;
    logic [SLOT_W-1:0] q_idx;
    logic [SLOT_W-1:0] idx_reg;

    logic              link_wr_en;
    logic [SLOT_W-1:0] link_wr_addr;
    logic [LINK_W-1:0] link_wr_data;
    logic              link_rd_en;
    logic [LINK_W-1:0] link_rd_data;

    logic              meta_wr_en;
    logic [SLOT_W-1:0] meta_wr_addr;
    logic [META_W-1:0] meta_wr_data;
    logic              meta_rd_en;
    logic [SLOT_W-1:0] meta_rd_addr;
    logic [META_W-1:0] meta_rd_data;
    logic              meta_ever;
    logic [GEN_W-1:0]  meta_gen;

    gsa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (head_idx),
        .rd_data (link_rd_data)
    );

    gsa_ram #(
        .WIDTH (META_W),
        .DEPTH (POOL_DEPTH)
    ) u_meta_ram (
        .aclk    (aclk),
        .wr_en   (meta_wr_en),
        .wr_addr (meta_wr_addr),
        .wr_data (meta_wr_data),
        .rd_en   (meta_rd_en),
        .rd_addr (meta_rd_addr),
        .rd_data (meta_rd_data)
    );

    assign out_can    = !m_valid_reg || m_tready;
    assign head_empty = (head_reg == LINK_W'(POOL_DEPTH));
    assign head_idx   = head_reg[SLOT_W-1:0];
    assign q_idx      = q_entry.slot_word[SLOT_W-1:0];
    assign idx_reg    = word_reg[SLOT_W-1:0];
    assign meta_ever  = meta_rd_data[GEN_W];
    assign meta_gen   = meta_rd_data[GEN_W-1:0];
    assign clearing   = (state_reg == ST_CLEAR);

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        head_next     = head_reg;
        op_next       = op_reg;
        word_next     = word_reg;
        cmp_gen_next  = cmp_gen_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_gen_next    = m_gen_reg;

        q_ready      = 1'b0;
        link_wr_en   = 1'b0;
        link_wr_addr = clr_cnt_reg;
        link_wr_data = LINK_W'(clr_cnt_reg) + LINK_W'(1);
        link_rd_en   = 1'b0;
        meta_wr_en   = 1'b0;
        meta_wr_addr = clr_cnt_reg;
        meta_wr_data = {1'b0, gsa_pkg::GEN_INIT};
        meta_rd_en   = 1'b0;
        meta_rd_addr = (q_entry.op == gsa_pkg::OP_ALLOC) ? head_idx : q_idx;

        case (state_reg)
            ST_CLEAR: begin
                link_wr_en   = 1'b1;
                meta_wr_en   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_W'(POOL_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_entry.op)
                        gsa_pkg::OP_ALLOC: begin
                            if (head_empty) begin
                                if (out_can) begin
                                    q_ready       = 1'b1;
                                    m_valid_next  = 1'b1;
                                    m_status_next = gsa_pkg::STAT_EMPTY;
                                    m_slot_next   = '0;
                                    m_gen_next    = '0;
                                end
                            end else begin
                                q_ready    = 1'b1;
                                link_rd_en = 1'b1;
                                meta_rd_en = 1'b1;
                                word_next  = WORD_W'(head_idx);
                                op_next    = gsa_pkg::OP_ALLOC;
                                state_next = ST_WAIT;
                            end
                        end
                        gsa_pkg::OP_FREE: begin
                            q_ready      = 1'b1;
                            meta_rd_en   = 1'b1;
                            link_wr_en   = 1'b1;
                            link_wr_addr = q_idx;
                            link_wr_data = head_reg;
                            head_next    = LINK_W'(q_idx);
                            word_next    = q_entry.slot_word;
                            op_next      = gsa_pkg::OP_FREE;
                            state_next   = ST_WAIT;
                        end
                        gsa_pkg::OP_DECODE: begin
                            q_ready      = 1'b1;
                            meta_rd_en   = 1'b1;
                            word_next    = q_entry.slot_word;
                            cmp_gen_next = q_entry.gen;
                            op_next      = gsa_pkg::OP_DECODE;
                            state_next   = ST_WAIT;
                        end
                        default: begin
                            if (out_can) begin
                                q_ready       = 1'b1;
                                m_valid_next  = 1'b1;
                                m_status_next = gsa_pkg::STAT_STALE;
                                m_slot_next   = q_entry.slot_word[7:0];
                                m_gen_next    = '0;
                            end
                        end
                    endcase
                end
            end
            ST_WAIT: begin
                if (out_can) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_slot_next  = word_reg[7:0];
                    meta_wr_addr = idx_reg;
                    case (op_reg)
                        gsa_pkg::OP_ALLOC: begin
                            meta_wr_en    = 1'b1;
                            meta_wr_data  = {1'b1, meta_gen};
                            head_next     = link_rd_data;
                            m_status_next = gsa_pkg::STAT_OK;
                            m_gen_next    = meta_gen;
                        end
                        gsa_pkg::OP_FREE: begin
                            meta_wr_en    = 1'b1;
                            meta_wr_data  = {meta_ever, meta_gen + GEN_W'(1)};
                            m_status_next = gsa_pkg::STAT_OK;
                            m_gen_next    = meta_gen + GEN_W'(1);
                        end
                        default: begin
                            m_status_next = (meta_ever && (meta_gen == cmp_gen_reg))
                                            ? gsa_pkg::STAT_OK : gsa_pkg::STAT_STALE;
                            m_gen_next    = meta_gen;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        word_reg     <= word_next;
        cmp_gen_reg  <= cmp_gen_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_gen_reg    <= m_gen_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_gen_reg, m_slot_reg, m_status_reg};

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= LINK_W'(POOL_DEPTH))
        else $error("free-stack head beyond end marker");

    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !q_ready)
        else $error("request taken during clearing pass");

    a_wait_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && m_valid_reg && !m_tready) |=> (state_reg == ST_WAIT))
        else $error("pending result dropped while output stalled");

endmodule

`default_nettype wire

>>> sim/generational_slot_allocator_unit_tb.sv
// Self-checking testbench for generational_slot_allocator_unit: directed table, then random
// allocate/free/decode traffic checked against an in-bench predictor of the slot pool.
// Depends on gsa_pkg and the RTL under rtl/.
module generational_slot_allocator_unit_tb;
    import gsa_pkg::*;

    localparam int POOL        = POOL_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 20;

    localparam logic [1:0] ACT_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [31:0] gen;
    } outcome_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slot;
        logic [63:0] handle;
        logic        typed;
        outcome_t    outcome;
    } vector_t;

    localparam outcome_t NONE = '0;

    localparam vector_t DIRECTED [23] = '{
        '{ACT_DECODE,  8'h00, 64'h00000001_00000000, 1'b1, '{STAT_STALE, 8'h00, 32'd1}},
        '{ACT_ALLOC,   8'h00, 64'h00000000_00000000, 1'b1, '{STAT_OK,    8'h00, 32'd1}},
        '{ACT_DECODE,  8'h00, 64'h00000001_00000000, 1'b1, '{STAT_OK,    8'h00, 32'd1}},
        '{ACT_ALLOC,   8'h00, 64'h00000000_00000000, 1'b1, '{STAT_OK,    8'h01, 32'd1}},
        '{ACT_FREE,    8'h00, 64'h00000000_00000000, 1'b1, '{STAT_OK,    8'h00, 32'd2}},
        '{ACT_DECODE,  8'h00, 64'h00000001_00000000, 1'b1, '{STAT_STALE, 8'h00, 32'd2}},
        '{ACT_DECODE,  8'h00, 64'h00000002_00000000, 1'b1, '{STAT_OK,    8'h00, 32'd2}},
        '{ACT_ALLOC,   8'hFF, 64'hFFFFFFFF_FFFFFFFF, 1'b0, NONE},
        '{ACT_DECODE,  8'h00, 64'hFFFFFFFF_FFFFFFFF, 1'b1, '{STAT_STALE, 8'hFF, 32'd0}},
        '{ACT_DECODE,  8'h00, 64'h00000000_00000100, 1'b1, '{STAT_STALE, 8'h00, 32'd0}},
        '{ACT_DECODE,  8'h00, 64'h00000000_000000FF, 1'b1, '{STAT_STALE, 8'hFF, 32'd1}},
        '{ACT_IGNORED, 8'hFF, 64'hFFFFFFFF_FFFFFFFF, 1'b0, NONE},
        '{ACT_DECODE,  8'h00, 64'h00000000_80000000, 1'b1, '{STAT_STALE, 8'h00, 32'd0}},
        '{ACT_ALLOC,   8'h00, 64'h00000000_00000000, 1'b0, NONE},
        '{ACT_FREE,    8'h01, 64'h00000000_00000000, 1'b0, NONE},
        '{ACT_FREE,    8'h02, 64'hFFFFFFFF_FFFFFFFF, 1'b0, NONE},
        '{ACT_ALLOC,   8'h00, 64'h00000000_00000000, 1'b0, NONE},
        '{ACT_ALLOC,   8'h00, 64'h00000000_00000000, 1'b0, NONE},
        '{ACT_DECODE,  8'h00, 64'h00000002_00000001, 1'b0, NONE},
        '{ACT_IGNORED, 8'h00, 64'h00000000_00000000, 1'b0, NONE},
        '{ACT_ALLOC,   8'hFF, 64'h00000000_00000000, 1'b0, NONE},
        '{ACT_FREE,    8'h03, 64'h00000000_00000000, 1'b0, NONE},
        '{ACT_DECODE,  8'hFF, 64'h00000002_00000003, 1'b0, NONE}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [8:0]  link_of [POOL];
    logic [8:0]  top_slot;
    logic [31:0] gen_of [POOL];
    logic        was_issued [POOL];

    outcome_t    pending_outcomes [$];
    logic [7:0]  live_slots [$];
    logic [63:0] retired_handles [$];

    bit quiet = 1'b0;
    int rx_hold = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int sent_count = 0;
    int checked_count = 0;
    int empty_hits = 0;
    int stale_hits = 0;

    generational_slot_allocator_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic apply_request(input logic [1:0] act, input logic [7:0] slot,
                                 input logic [63:0] handle, output bit yields,
                                 output outcome_t o);
        logic [8:0]  s;
        logic [31:0] idx;
        logic [31:0] want;
        yields = 1'b1;
        o = NONE;
        case (act)
            ACT_ALLOC: begin
                s = top_slot;
                if (s >= POOL) begin
                    o.status = STAT_EMPTY;
                end else begin
                    top_slot = link_of[s];
                    was_issued[s] = 1'b1;
                    o = '{STAT_OK, s[7:0], gen_of[s]};
                end
            end
            ACT_FREE: begin
                s = {1'b0, slot};
                if (s >= POOL) begin
                    o = '{STAT_STALE, slot, 32'd0};
                end else begin
                    gen_of[s] = gen_of[s] + 32'd1;
                    link_of[s] = top_slot;
                    top_slot = s;
                    o = '{STAT_OK, slot, gen_of[s]};
                end
            end
            ACT_DECODE: begin
                idx = handle[31:0];
                want = handle[63:32];
                if (idx >= POOL)
                    o = '{STAT_STALE, idx[7:0], 32'd0};
                else if (was_issued[idx] && gen_of[idx] == want)
                    o = '{STAT_OK, idx[7:0], gen_of[idx]};
                else
                    o = '{STAT_STALE, idx[7:0], gen_of[idx]};
            end
            default: yields = 1'b0;
        endcase
    endtask

    task automatic issue_request(input logic [1:0] act, input logic [7:0] slot,
                                 input logic [63:0] handle, input logic typed,
                                 input outcome_t typed_out);
        bit       yields;
        outcome_t o;
        int       k;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, handle, slot, act};
        do @(posedge aclk); while (!s_tready);
        apply_request(act, slot, handle, yields, o);
        sent_count++;
        if (yields) begin
            pending_outcomes.push_back(typed ? typed_out : o);
            if (o.status == STAT_EMPTY)
                empty_hits++;
            if (act == ACT_DECODE && o.status == STAT_STALE)
                stale_hits++;
            if (act == ACT_ALLOC && o.status == STAT_OK)
                live_slots.push_back(o.slot);
            if (act == ACT_FREE && o.status == STAT_OK) begin
                k = 0;
                while (k < live_slots.size()) begin
                    if (live_slots[k] == o.slot)
                        live_slots.delete(k);
                    else
                        k++;
                end
                retired_handles.push_back({o.gen - 32'd1, 24'd0, o.slot});
                if (retired_handles.size() > 64)
                    void'(retired_handles.pop_front());
            end
        end
    endtask

    task automatic random_request(input int alloc_pct, input int free_pct,
                                  input int stray_pct);
        logic [1:0]  act;
        logic [7:0]  slot;
        logic [63:0] handle;
        int          r;
        r = $urandom_range(0, 99);
        slot = 8'($urandom);
        handle = {$urandom, $urandom};
        if (r < 4) begin
            act = ACT_IGNORED;
        end else if (r < 4 + alloc_pct) begin
            act = ACT_ALLOC;
        end else if (r < 4 + alloc_pct + free_pct) begin
            act = ACT_FREE;
            if (live_slots.size() > 0 && $urandom_range(0, 99) >= stray_pct)
                slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
            else if (stray_pct == 0)
                act = ACT_ALLOC;
        end else begin
            act = ACT_DECODE;
            case ($urandom_range(0, 5))
                0, 1: begin
                    if (live_slots.size() > 0) begin
                        slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
                        handle = {gen_of[slot], 24'd0, slot};
                    end
                end
                2: begin
                    if (retired_handles.size() > 0)
                        handle = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
                end
                3: begin
                    handle[31:0] = 32'($urandom_range(0, POOL - 1));
                    handle[63:32] = gen_of[handle[7:0]] + 32'($urandom_range(0, 2)) - 32'd1;
                end
                4: handle[31:8] = '0;
                default: ;
            endcase
        end
        issue_request(act, slot, handle, 1'b0, NONE);
    endtask

    task automatic wait_for_outcomes();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_outcomes.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[9:2], m_tdata[41:10]};
            if (pending_outcomes.size() == 0) begin
                $error("result with nothing pending: status %0d slot %0d generation %0d",
                       got.status, got.slot, got.gen);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                checked_count++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot_out: expected %0d, got %0d", want.slot, got.slot);
                    mismatches++;
                end
                if (got.gen !== want.gen) begin
                    $error("generation_out: expected %0d, got %0d", want.gen, got.gen);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("generational_slot_allocator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < POOL; i++) begin
            link_of[i] = 9'(i + 1);
            gen_of[i] = 32'd1;
            was_issued[i] = 1'b0;
        end
        top_slot = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i])
            issue_request(DIRECTED[i].action, DIRECTED[i].slot, DIRECTED[i].handle,
                          DIRECTED[i].typed, DIRECTED[i].outcome);

        // drain the pool until allocations keep finding it empty
        while (empty_hits < 10)
            random_request(85, 5, 0);
        wait_for_outcomes();

        for (int i = 0; i < 300; i++)
            random_request(40, 35, 0);

        // stray and repeated frees last: they can leave a loop on the free stack
        for (int i = 0; i < 130; i++) begin
            if (i == 30)
                quiet = 1'b1;
            random_request(40, 35, 20);
        end

        wait_for_outcomes();
        repeat (SETTLE) @(posedge aclk);

        $display("requests sent %0d, results compared %0d", sent_count, checked_count);
        $display("empty-pool allocations %0d, rejected decodes %0d", empty_hits, stale_hits);
        if (mismatches == 0)
            $display("generational_slot_allocator_unit: match");
        else
            $display("generational_slot_allocator_unit: mismatch");
        $finish;
    end
endmodule
